@@ rtl/core/ghp_pkg.sv @@
package ghp_pkg;

    // Byte kind codes as they appear on the output
    localparam logic [2:0] K_FIXED   = 3'd0;
    localparam logic [2:0] K_XLEN    = 3'd1;
    localparam logic [2:0] K_XDATA   = 3'd2;
    localparam logic [2:0] K_NAME    = 3'd3;
    localparam logic [2:0] K_COMMENT = 3'd4;
    localparam logic [2:0] K_CRC     = 3'd5;
    localparam logic [2:0] K_BODY    = 3'd6;

    // Flag bits of the fixed header
    localparam logic [7:0] FL_HCRC    = 8'h02;
    localparam logic [7:0] FL_EXTRA   = 8'h04;
    localparam logic [7:0] FL_NAME    = 8'h08;
    localparam logic [7:0] FL_COMMENT = 8'h10;

    localparam logic [15:0] FIXED_LEN  = 16'd10;
    localparam logic [15:0] FLAG_POS   = 16'd7;   // count left when the flag byte arrives
    localparam logic [15:0] TWO_BYTES  = 16'd2;

    typedef enum logic [6:0] {
        PH_FIXED   = 7'b0000001,
        PH_XLEN    = 7'b0000010,
        PH_XDATA   = 7'b0000100,
        PH_NAME    = 7'b0001000,
        PH_COMMENT = 7'b0010000,
        PH_CRC     = 7'b0100000,
        PH_BODY    = 7'b1000000
    } t_phase;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase      phase;
        logic [15:0] bytes_left;
        logic [7:0]  flags;
        logic [7:0]  xlen_lo;
    } t_state;

    // Phase chosen after a part ends, plus whether a 2-byte count starts
    typedef struct packed {
        t_phase phase;
        logic   load_two;
    } t_sel;

    function automatic logic [2:0] kind_of(input t_phase ph);
        logic [2:0] k;
        case (ph)
            PH_FIXED:   k = K_FIXED;
            PH_XLEN:    k = K_XLEN;
            PH_XDATA:   k = K_XDATA;
            PH_NAME:    k = K_NAME;
            PH_COMMENT: k = K_COMMENT;
            PH_CRC:     k = K_CRC;
            default:    k = K_BODY;
        endcase
        return k;
    endfunction

    // Pick the part that follows 'done' from the captured flags
    function automatic t_sel next_part(input logic [2:0] done, input logic [7:0] fl);
        t_sel s;
        s.load_two = 1'b0;
        if (done == K_FIXED && (fl & FL_EXTRA) != 8'h00) begin
            s.phase    = PH_XLEN;
            s.load_two = 1'b1;
        end else if (done <= K_XDATA && (fl & FL_NAME) != 8'h00) begin
            s.phase = PH_NAME;
        end else if (done <= K_NAME && (fl & FL_COMMENT) != 8'h00) begin
            s.phase = PH_COMMENT;
        end else if (done <= K_COMMENT && (fl & FL_HCRC) != 8'h00) begin
            s.phase    = PH_CRC;
            s.load_two = 1'b1;
        end else begin
            s.phase = PH_BODY;
        end
        return s;
    endfunction

endpackage

@@ rtl/core/ghp_step.sv @@
module ghp_step (
    input  ghp_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    output ghp_pkg::t_state o_state,
    output logic [2:0]      o_kind,
    output logic            o_complete
);

    ghp_pkg::t_state nxt;
    ghp_pkg::t_sel   sel;
    logic [15:0]     dec;
    logic [15:0]     xlen;

    assign dec  = (i_state.bytes_left != 16'd0) ? i_state.bytes_left - 16'd1 : 16'd0;
    assign xlen = {i_byte, i_state.xlen_lo};

    // Advance the header state by one byte
    always_comb begin
        nxt    = i_state;
        sel    = ghp_pkg::next_part(ghp_pkg::K_BODY, i_state.flags);
        o_kind = ghp_pkg::kind_of(i_state.phase);
        case (i_state.phase)
            ghp_pkg::PH_FIXED: begin
                if (i_state.bytes_left == ghp_pkg::FLAG_POS) begin
                    nxt.flags = i_byte;
                end
                nxt.bytes_left = dec;
                if (dec == 16'd0) begin
                    sel       = ghp_pkg::next_part(ghp_pkg::K_FIXED, nxt.flags);
                    nxt.phase = sel.phase;
                    if (sel.load_two) begin
                        nxt.bytes_left = ghp_pkg::TWO_BYTES;
                    end
                end
            end
            ghp_pkg::PH_XLEN: begin
                if (i_state.bytes_left == ghp_pkg::TWO_BYTES) begin
                    nxt.xlen_lo    = i_byte;
                    nxt.bytes_left = 16'd1;
                end else if (xlen != 16'd0) begin
                    nxt.bytes_left = xlen;
                    nxt.phase      = ghp_pkg::PH_XDATA;
                end else begin
                    // zero extra length: skip the extra data
                    nxt.bytes_left = 16'd0;
                    sel            = ghp_pkg::next_part(ghp_pkg::K_XDATA, i_state.flags);
                    nxt.phase      = sel.phase;
                    if (sel.load_two) begin
                        nxt.bytes_left = ghp_pkg::TWO_BYTES;
                    end
                end
            end
            ghp_pkg::PH_XDATA: begin
                nxt.bytes_left = dec;
                if (dec == 16'd0) begin
                    sel       = ghp_pkg::next_part(ghp_pkg::K_XDATA, i_state.flags);
                    nxt.phase = sel.phase;
                    if (sel.load_two) begin
                        nxt.bytes_left = ghp_pkg::TWO_BYTES;
                    end
                end
            end
            ghp_pkg::PH_NAME: begin
                if (i_byte == 8'h00) begin
                    sel       = ghp_pkg::next_part(ghp_pkg::K_NAME, i_state.flags);
                    nxt.phase = sel.phase;
                    if (sel.load_two) begin
                        nxt.bytes_left = ghp_pkg::TWO_BYTES;
                    end
                end
            end
            ghp_pkg::PH_COMMENT: begin
                if (i_byte == 8'h00) begin
                    sel       = ghp_pkg::next_part(ghp_pkg::K_COMMENT, i_state.flags);
                    nxt.phase = sel.phase;
                    if (sel.load_two) begin
                        nxt.bytes_left = ghp_pkg::TWO_BYTES;
                    end
                end
            end
            ghp_pkg::PH_CRC: begin
                nxt.bytes_left = dec;
                if (dec == 16'd0) begin
                    nxt.phase = ghp_pkg::PH_BODY;
                end
            end
            default: begin
                o_kind    = ghp_pkg::K_BODY;
                nxt.phase = ghp_pkg::PH_BODY;
            end
        endcase
    end

    assign o_state    = nxt;
    assign o_complete = (o_kind != ghp_pkg::K_BODY) && (nxt.phase == ghp_pkg::PH_BODY);

endmodule

@@ rtl/core/gzip_header_parser.sv @@
// gzip member header parser. Each byte on the slave stream comes out on the
// master stream unchanged, labeled with its part of the header (fixed header,
// extra length, extra data, name, comment, header CRC) or as body, together
// with the flag byte of the fixed header. tlast is high on the byte that
// completes the header. One byte is taken per clock with no gaps while the
// master side does not stall; a byte passes the input register, then the
// result register, and the rate is set by the single header state update
// made per byte. Magic and method bytes are not checked; after the header
// every byte is body until reset.
module gzip_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // header_complete
    output logic [10:0] m_axis_tuser    // [2:0] byte_kind, [10:3] header_flags
);

    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    logic            r_out_vld;
    logic [7:0]      r_out_byte;
    logic [2:0]      r_out_kind;
    logic            r_out_last;
    logic [7:0]      r_out_flags;
    ghp_pkg::t_state r_state;
    ghp_pkg::t_state n_state;
    logic [2:0]      n_kind;
    logic            n_last;
    logic            advance;

    // Move the held byte into the result register when it is free or draining
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    ghp_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .o_state    (n_state),
        .o_kind     (n_kind),
        .o_complete (n_last)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Header state, updated once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= ghp_pkg::PH_FIXED;
            r_state.bytes_left <= ghp_pkg::FIXED_LEN;
            r_state.flags      <= 8'h00;
            r_state.xlen_lo    <= 8'h00;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (advance) begin
            r_out_byte  <= r_in_byte;
            r_out_kind  <= n_kind;
            r_out_last  <= n_last;
            r_out_flags <= n_state.flags;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_flags, r_out_kind};

    // The completing byte is always a header byte
    a_last_is_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[2:0] != ghp_pkg::K_BODY))
        else $error("header complete flagged on a body byte");

    // Once in the body, the parser stays there
    a_body_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == ghp_pkg::PH_BODY) |=> (r_state.phase == ghp_pkg::PH_BODY))
        else $error("parser left the body phase");

    // A held input byte is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("held input byte dropped or changed");

    // State only moves when a byte moves to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("header state changed without a transfer");

endmodule

@@ tb/tb_gzip_header_parser.sv @@
module tb_gzip_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int BODY_PER_PHASE = 480;

    // One labeled byte as it leaves the parser
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
        logic [7:0] flags;
    } t_labeled_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [7:0] out_byte
    logic        m_axis_tlast;    // header_complete
    logic [10:0] m_axis_tuser;    // [2:0] byte_kind, [10:3] header_flags

    // Header tracking of the testbench's own parser copy
    logic [2:0]  hdr_part;
    logic [15:0] hdr_left;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_xlen_lo;

    t_labeled_byte expected_labels[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int bytes_sent;
    int bytes_checked;
    int header_bytes;
    int idle_cycles;

    logic [7:0]  test_flags;
    logic [15:0] test_xlen;

    gzip_header_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation
    always #5 i_clk = ~i_clk;

    // Pick the optional part that follows a finished one
    function automatic logic [2:0] part_after(input logic [2:0] done, input logic [7:0] fl);
        if (done == ghp_pkg::K_FIXED && (fl & ghp_pkg::FL_EXTRA) != 8'h00)
            return ghp_pkg::K_XLEN;
        if (done <= ghp_pkg::K_XDATA && (fl & ghp_pkg::FL_NAME) != 8'h00)
            return ghp_pkg::K_NAME;
        if (done <= ghp_pkg::K_NAME && (fl & ghp_pkg::FL_COMMENT) != 8'h00)
            return ghp_pkg::K_COMMENT;
        if (done <= ghp_pkg::K_COMMENT && (fl & ghp_pkg::FL_HCRC) != 8'h00)
            return ghp_pkg::K_CRC;
        return ghp_pkg::K_BODY;
    endfunction

    // Label one accepted byte and advance the header tracking
    task automatic label_byte(input logic [7:0] b);
        t_labeled_byte lb;
        logic [2:0]    nxt;
        logic [15:0]   xlen;
        lb.data = b;
        lb.kind = hdr_part;
        nxt     = hdr_part;
        case (hdr_part)
            ghp_pkg::K_FIXED: begin
                if (hdr_left == ghp_pkg::FIXED_LEN - 16'd3) hdr_flags = b;
                if (hdr_left != 16'd0) hdr_left = hdr_left - 16'd1;
                if (hdr_left == 16'd0) nxt = part_after(ghp_pkg::K_FIXED, hdr_flags);
            end
            ghp_pkg::K_XLEN: begin
                if (hdr_left == 16'd2) begin
                    hdr_xlen_lo = b;
                    hdr_left    = 16'd1;
                end else begin
                    xlen = {b, hdr_xlen_lo};
                    hdr_left = xlen;
                    // an empty extra field skips straight to the next part
                    nxt = (xlen != 16'd0) ? ghp_pkg::K_XDATA
                                          : part_after(ghp_pkg::K_XDATA, hdr_flags);
                end
            end
            ghp_pkg::K_XDATA: begin
                if (hdr_left != 16'd0) hdr_left = hdr_left - 16'd1;
                if (hdr_left == 16'd0) nxt = part_after(ghp_pkg::K_XDATA, hdr_flags);
            end
            ghp_pkg::K_NAME: begin
                if (b == 8'h00) nxt = part_after(ghp_pkg::K_NAME, hdr_flags);
            end
            ghp_pkg::K_COMMENT: begin
                if (b == 8'h00) nxt = part_after(ghp_pkg::K_COMMENT, hdr_flags);
            end
            ghp_pkg::K_CRC: begin
                if (hdr_left != 16'd0) hdr_left = hdr_left - 16'd1;
                if (hdr_left == 16'd0) nxt = ghp_pkg::K_BODY;
            end
            default: begin
                lb.kind = ghp_pkg::K_BODY;
                nxt     = ghp_pkg::K_BODY;
            end
        endcase
        // two-byte counted parts load their count on entry
        if (nxt != hdr_part && (nxt == ghp_pkg::K_XLEN || nxt == ghp_pkg::K_CRC))
            hdr_left = ghp_pkg::TWO_BYTES;
        lb.last  = (lb.kind != ghp_pkg::K_BODY && nxt == ghp_pkg::K_BODY);
        lb.flags = hdr_flags;
        if (lb.kind != ghp_pkg::K_BODY) header_bytes++;
        hdr_part = nxt;
        expected_labels.push_back(lb);
    endtask

    // Offer one byte, with random idle cycles ahead of it, and wait for the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        label_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Hold the input until every labeled byte has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_labels.size() != 0) @(negedge i_clk);
    endtask

    // Fixed part: magic, method, flags, mtime, extra flags, OS
    task automatic test_fixed_header();
        send_byte(8'h1F);
        send_byte(8'h8B);
        send_byte(8'h08);
        send_byte(test_flags);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'($urandom));
        send_byte(8'h80);
        send_byte(8'h02);
        send_byte(8'hFF);
    endtask

    // Extra length, little endian, then the extra data
    task automatic test_extra_field();
        if ((test_flags & ghp_pkg::FL_EXTRA) != 8'h00) begin
            send_byte(test_xlen[7:0]);
            send_byte(test_xlen[15:8]);
            for (int i = 0; i < int'(test_xlen); i++)
                send_byte((i == 0) ? 8'h00 : 8'($urandom));
        end
    endtask

    // Zero-terminated name and comment
    task automatic test_name_comment();
        int len;
        if ((test_flags & ghp_pkg::FL_NAME) != 8'h00) begin
            len = $urandom_range(1, 3);
            send_byte(8'hFF);
            for (int i = 1; i < len; i++) send_byte(8'($urandom_range(1, 255)));
            send_byte(8'h00);
        end
        if ((test_flags & ghp_pkg::FL_COMMENT) != 8'h00) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(1, 255)));
            send_byte(8'h00);
        end
    endtask

    // Header CRC is exactly two bytes
    task automatic test_header_crc();
        if ((test_flags & ghp_pkg::FL_HCRC) != 8'h00) begin
            send_byte(8'h00);
            send_byte(8'hFF);
        end
    endtask

    // Body bytes: random, with zeros and all-ones mixed in
    task automatic test_body_random(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    // Random backpressure on the result side
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result transfer with the oldest labeled byte
    always @(posedge i_clk) begin
        t_labeled_byte lb;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_labels.size() == 0) begin
                $error("unexpected result: data %02h kind %0d", m_axis_tdata, m_axis_tuser[2:0]);
                error_count++;
            end else begin
                lb = expected_labels.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== lb.data) begin
                    $error("out_byte: expected %02h, got %02h", lb.data, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[2:0] !== lb.kind) begin
                    $error("byte_kind: expected %0d, got %0d", lb.kind, m_axis_tuser[2:0]);
                    error_count++;
                end
                if (m_axis_tlast !== lb.last) begin
                    $error("header_complete: expected %0b, got %0b", lb.last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser[10:3] !== lb.flags) begin
                    $error("header_flags: expected %02h, got %02h",
                           lb.flags, m_axis_tuser[10:3]);
                    error_count++;
                end
            end
        end
    end

    // Stop a run in which no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        send_idle_pct  = 15;
        recv_stall_pct = 51;
        error_count    = 0;
        bytes_sent     = 0;
        bytes_checked  = 0;
        header_bytes   = 0;
        hdr_part       = ghp_pkg::K_FIXED;
        hdr_left       = ghp_pkg::FIXED_LEN;
        hdr_flags      = 8'h00;
        hdr_xlen_lo    = 8'h00;

        // One header per reset, so the seed picks its shape
        case ($urandom_range(0, 2))
            0: begin
                // all flag bits, empty extra field
                test_flags = 8'hFF;
                test_xlen  = 16'd0;
            end
            1: begin
                test_flags = ghp_pkg::FL_EXTRA | ghp_pkg::FL_NAME | ghp_pkg::FL_COMMENT
                           | ghp_pkg::FL_HCRC;
                test_xlen  = 16'($urandom_range(1, 4));
            end
            default: begin
                // reserved bits and the text bit only: header ends on the tenth byte
                test_flags = 8'hE1;
                test_xlen  = 16'd0;
            end
        endcase

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles lightly, receiver stalls often
        test_fixed_header();
        test_extra_field();
        test_name_comment();
        test_header_crc();
        test_body_random(BODY_PER_PHASE);
        wait_drained();

        // receiver stalls lightly, sender idles often
        send_idle_pct  = 51;
        recv_stall_pct = 15;
        test_body_random(BODY_PER_PHASE);

        // full rate
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_body_random(BODY_PER_PHASE);

        s_axis_tvalid <= 1'b0;
        while (expected_labels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_labels.size() != 0) begin
            $error("%0d labeled bytes never came out", expected_labels.size());
            error_count++;
        end

        $display("Header with flags %02h spanned %0d bytes; %0d bytes sent, %0d checked.",
                 test_flags, header_bytes, bytes_sent, bytes_checked);
        $display("Body ran under heavy, light and no backpressure and source gaps.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
